@@ src/stepper_halfstep_driver_macros.svh @@
// Assertion macros for the stepper half-step driver checker.
`ifndef STEPPER_HALFSTEP_DRIVER_MACROS_SVH
`define STEPPER_HALFSTEP_DRIVER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define STPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define STPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/stpd_pkg.sv @@
// Shared types and constants for the stepper half-step driver.
`default_nettype none
package stpd_pkg;

  // Input item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // Register word indexes
  localparam logic REG_STEP_DELAY = 1'b0;

  localparam logic [3:0] STEP_DELAY_RESET = 4'd1;

  localparam logic [2:0] PHASE_FIRST = 3'd0;
  localparam logic [2:0] PHASE_LAST  = 3'd7;

  // Half-step coil patterns, bit0 = coil one
  localparam logic [3:0] PHASE_BITS [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
  };

  typedef struct packed {
    logic [3:0] coils;
    logic       busy;
    logic [3:0] lit;
    logic       done;
  } result_t;

endpackage
`default_nettype wire

@@ src/stpd_cfg.sv @@
// APB-style register port holding the step delay.
`default_nettype none
module stpd_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [3:0]  step_delay
);

  logic wr_en;
  logic hit;

  // Word index only; byte lanes ignored
  assign hit    = (paddr[2] == stpd_pkg::REG_STEP_DELAY);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_delay <= stpd_pkg::STEP_DELAY_RESET;
    end else if (wr_en) begin
      step_delay <= pwdata[3:0];
    end
  end

  assign prdata = hit ? {28'd0, step_delay} : 32'd0;

endmodule
`default_nettype wire

@@ src/stpd_interval.sv @@
// Progress interval unit: total sequences divided by the LED count.
`default_nettype none
module stpd_interval #(
  parameter int LED_COUNT = 13,
  parameter int SEQ_W     = 15,
  parameter int IW        = 11
) (
  input  logic             clk,
  input  logic             start,
  input  logic [SEQ_W-1:0] total,
  output logic [IW-1:0]    interval
);

  // Exact reciprocal: floor(n / L) = (n * M) >> S for every SEQ_W-bit n
  localparam int MW = SEQ_W + 1;
  localparam int PW = SEQ_W + MW;
  localparam int S  = SEQ_W + $clog2(LED_COUNT);
  localparam longint unsigned MUL_L =
    ((64'd1 << S) + longint'(LED_COUNT) - 64'd1) / longint'(LED_COUNT);
  localparam logic [MW-1:0] MUL = MW'(MUL_L);

  logic [SEQ_W-1:0] tot_q;
  logic [PW-1:0]    prod;
  logic [PW-1:0]    shifted;
  logic [IW-1:0]    quot;

  always_ff @(posedge clk) begin
    if (start) begin
      tot_q <= total;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PW'(tot_q) * PW'(MUL);
  end

  assign shifted = prod >> S;
  assign quot    = IW'(shifted);

  // Registered after the product register, ready well before the first sequence ends
  always_ff @(posedge clk) begin
    interval <= (quot == '0) ? IW'(1) : quot;
  end

endmodule
`default_nettype wire

@@ src/stpd_core.sv @@
// Half-step sequencer state and per-beat result logic.
`default_nettype none
module stpd_core #(
  parameter int LED_COUNT             = 13,
  parameter int SEQUENCES_PER_QUARTER = 128,
  parameter int SEQ_W                 = 15,
  parameter int IW                    = 11,
  parameter int LW                    = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic                   kind,
  input  logic signed [7:0]      quarter_turns,
  input  logic                   lights_on,
  input  logic [3:0]             step_delay,
  input  logic [IW-1:0]          interval,
  output logic                   start,
  output logic [SEQ_W-1:0]       total,
  output stpd_pkg::result_t      res
);

  logic             running, running_next;
  logic             reverse, reverse_next;
  logic [2:0]       phase, phase_next;
  logic [3:0]       hold_count, hold_count_next;
  logic [SEQ_W-1:0] seq_left, seq_left_next;
  logic [IW-1:0]    countdown, countdown_next;
  logic [LW-1:0]    lit_leds, lit_leds_next;
  logic [3:0]       coil_pattern, coil_pattern_next;

  logic [7:0]       q_raw;
  logic [7:0]       mag;
  logic [3:0]       delay_eff;
  logic [3:0]       hold_dec;
  logic [SEQ_W-1:0] seq_dec;
  logic [2:0]       last_phase;
  logic             load_en;
  logic [2:0]       load_p;
  logic             done;

  assign q_raw     = quarter_turns;
  // Two's complement magnitude; -128 comes out as 128
  assign mag       = q_raw[7] ? (~q_raw + 8'd1) : q_raw;
  assign total     = SEQ_W'(mag) * SEQ_W'(SEQUENCES_PER_QUARTER);
  assign delay_eff = (step_delay == 4'd0) ? 4'd1 : step_delay;
  assign hold_dec  = (hold_count != 4'd0) ? hold_count - 4'd1 : 4'd0;
  assign seq_dec   = seq_left - SEQ_W'(1);
  assign last_phase = reverse ? stpd_pkg::PHASE_FIRST : stpd_pkg::PHASE_LAST;

  always_comb begin
    running_next      = running;
    reverse_next      = reverse;
    phase_next        = phase;
    hold_count_next   = hold_count;
    seq_left_next     = seq_left;
    countdown_next    = countdown;
    lit_leds_next     = lit_leds;
    coil_pattern_next = coil_pattern;
    load_en           = 1'b0;
    load_p            = phase;
    done              = 1'b0;
    start             = 1'b0;

    if (fire) begin
      if (kind == stpd_pkg::KIND_START) begin
        // Start while busy is dropped
        if (!running) begin
          lit_leds_next = '0;
          if (mag == 8'd0) begin
            running_next   = 1'b0;
            seq_left_next  = '0;
            countdown_next = '0;
            done           = 1'b1;
          end else begin
            running_next   = 1'b1;
            reverse_next   = q_raw[7];
            seq_left_next  = total;
            countdown_next = '0;
            start          = 1'b1;
            load_en        = 1'b1;
            load_p         = q_raw[7] ? stpd_pkg::PHASE_LAST : stpd_pkg::PHASE_FIRST;
          end
        end
      end else if (running) begin
        hold_count_next = hold_dec;
        if (hold_dec == 4'd0) begin
          if (phase != last_phase) begin
            load_en = 1'b1;
            load_p  = reverse ? phase - 3'd1 : phase + 3'd1;
          end else begin
            // End of a sequence: advance progress, then next sequence or finish
            if (countdown == '0) begin
              if (!lights_on && (lit_leds < LW'(LED_COUNT))) begin
                lit_leds_next = lit_leds + LW'(1);
              end
              countdown_next = interval - IW'(1);
            end else begin
              countdown_next = countdown - IW'(1);
            end
            seq_left_next = seq_dec;
            if (seq_dec == '0) begin
              running_next   = 1'b0;
              lit_leds_next  = '0;
              seq_left_next  = '0;
              countdown_next = '0;
              done           = 1'b1;
            end else begin
              load_en = 1'b1;
              load_p  = reverse ? stpd_pkg::PHASE_LAST : stpd_pkg::PHASE_FIRST;
            end
          end
        end
      end
    end

    if (load_en) begin
      phase_next        = load_p;
      coil_pattern_next = stpd_pkg::PHASE_BITS[load_p];
      hold_count_next   = delay_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      reverse      <= 1'b0;
      phase        <= '0;
      hold_count   <= '0;
      seq_left     <= '0;
      countdown    <= '0;
      lit_leds     <= '0;
      coil_pattern <= '0;
    end else begin
      running      <= running_next;
      reverse      <= reverse_next;
      phase        <= phase_next;
      hold_count   <= hold_count_next;
      seq_left     <= seq_left_next;
      countdown    <= countdown_next;
      lit_leds     <= lit_leds_next;
      coil_pattern <= coil_pattern_next;
    end
  end

  always_comb begin
    res.coils = coil_pattern_next;
    res.busy  = running_next;
    res.lit   = 4'(lit_leds_next);
    res.done  = done;
  end

endmodule
`default_nettype wire

@@ src/stpd_skid.sv @@
// Output register with a one-beat skid stage.
`default_nettype none
module stpd_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  stpd_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output stpd_pkg::result_t out_data
);

  logic              sk_valid;
  stpd_pkg::result_t sk_data;
  logic              out_free;

  assign full     = sk_valid;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (out_free) begin
      if (sk_valid) begin
        out_valid <= 1'b1;
        sk_valid  <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      // Output held: park the beat in the skid stage
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (sk_valid) begin
        out_data <= sk_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      sk_data <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ src/stepper_halfstep_driver.sv @@
// Top level of the four-coil stepper half-step driver with progress bar.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   input    | in_valid / in_stall   | kind, quarter_turns, lights_on
//   output   | out_valid / out_stall | coils, busy_res, lit_count, done_res
//   config   | psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// One item per cycle while in_stall is low; each accepted beat yields one result beat.
// The core state updates on the accepted beat itself, straight into the
// output register (or the skid stage when the output is held); the divide
// for the progress interval runs behind a start in its own multiplier pipeline.
// A stalled output parks one beat in the skid stage; in_stall rises only then.
// Synchronous reset clears the sequencer, handshake state and sets step delay 1.
`default_nettype none
module stepper_halfstep_driver #(
  parameter int LED_COUNT             = 13,
  parameter int SEQUENCES_PER_QUARTER = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  input  logic signed [7:0] quarter_turns,
  input  logic              lights_on,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        coils,
  output logic              busy_res,
  output logic [3:0]        lit_count,
  output logic              done_res
);

  localparam int MAX_TOTAL = 128 * SEQUENCES_PER_QUARTER;
  localparam int SEQ_W     = $clog2(MAX_TOTAL + 1);
  localparam int IW_RAW    = $clog2(MAX_TOTAL / LED_COUNT + 1);
  localparam int IW        = (IW_RAW < 1) ? 1 : IW_RAW;
  localparam int LW        = $clog2(LED_COUNT + 1);

  logic              fire;
  logic [3:0]        step_delay;
  logic [IW-1:0]     interval;
  logic              start;
  logic [SEQ_W-1:0]  total;
  logic              full;
  stpd_pkg::result_t res;
  stpd_pkg::result_t out_data;

  assign in_stall = full;
  assign fire     = in_valid && !in_stall;

  stpd_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .step_delay (step_delay)
  );

  stpd_interval #(
    .LED_COUNT (LED_COUNT),
    .SEQ_W     (SEQ_W),
    .IW        (IW)
  ) u_interval (
    .clk      (clk),
    .start    (start),
    .total    (total),
    .interval (interval)
  );

  stpd_core #(
    .LED_COUNT             (LED_COUNT),
    .SEQUENCES_PER_QUARTER (SEQUENCES_PER_QUARTER),
    .SEQ_W                 (SEQ_W),
    .IW                    (IW),
    .LW                    (LW)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .kind          (kind),
    .quarter_turns (quarter_turns),
    .lights_on     (lights_on),
    .step_delay    (step_delay),
    .interval      (interval),
    .start         (start),
    .total         (total),
    .res           (res)
  );

  stpd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign coils     = out_data.coils;
  assign busy_res  = out_data.busy;
  assign lit_count = out_data.lit;
  assign done_res  = out_data.done;

endmodule
`default_nettype wire

@@ src/stpd_checker.sv @@
// Port-level checker for the stepper half-step driver, bound to the top level.
`default_nettype none
`include "stepper_halfstep_driver_macros.svh"
module stpd_checker #(
  parameter int LED_COUNT = 13
) (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] coils,
  input logic       busy_res,
  input logic [3:0] lit_count,
  input logic       done_res
);

  // A finishing beat shows an idle motor and a cleared bar
  `STPD_ASSERT_NOW(a_done_clears, out_valid && done_res, !busy_res && (lit_count == 4'd0), "done beat with busy or lit LEDs")

  // The bar never counts past its length
  `STPD_ASSERT_NOW(a_lit_bound, out_valid, (LED_COUNT > 15) || (int'(lit_count) <= LED_COUNT), "lit count beyond LED count")

  // Input stalls only while a result sits held at the output
  `STPD_ASSERT_NOW(a_stall_held, in_stall, out_valid, "input stalled with empty output")

  // A stalled result beat holds
  `STPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(coils) && $stable(lit_count) && $stable(done_res), "stalled result beat changed")

endmodule

bind stepper_halfstep_driver stpd_checker #(.LED_COUNT(LED_COUNT)) u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .coils     (coils),
  .busy_res  (busy_res),
  .lit_count (lit_count),
  .done_res  (done_res)
);
`default_nettype wire
